[rtl/core/dbd_pkg.sv]
// Shared types, constants and calendar helpers for the day-difference block.
`default_nettype none

package dbd_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned ACC_W  = 24;
  localparam int unsigned DAYS_W = 23;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned TOD_W  = 17;

  localparam logic [YEAR_W-1:0] CYCLE_LEN   = 14'd400;
  localparam logic [YEAR_W-1:0] CENTURY     = 14'd100;
  localparam logic [CNT_W-1:0]  MOD_STEPS   = 3'd5;
  localparam logic [ACC_W-1:0]  DAYS_COMMON = 24'd365;
  localparam logic [ACC_W-1:0]  DAYS_LEAP   = 24'd366;
  localparam logic signed [ACC_W-1:0] RESULT_MAX = 24'sd4194303;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_DOYS,
    S_WALK,
    S_DOYE,
    S_TOD,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOD,
    OP_DOYS,
    OP_WALK,
    OP_DOYE,
    OP_TOD
  } op_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    op_t  op;
    logic acc_we;
    logic rem_step;
    logic year_step;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic year_done;
    logic year_back;
    logic out_free;
  } status_t;

  // Days in a common year before the first of month m (1 is January).
  function automatic logic [8:0] month_start(logic [3:0] m);
    logic [8:0] days;
    case (m)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  function automatic logic [8:0] date_ordinal(logic [3:0] month, logic [4:0] day,
                                              logic leap);
    logic [3:0] m;
    logic [8:0] total;
    m = (month > 4'd12) ? 4'd12 : month;
    if (m == 4'd0) begin
      total = 9'd0;
    end else begin
      total = month_start(m) + {8'd0, (leap && (m > 4'd2))} + {4'd0, day};
    end
    return total;
  endfunction

  function automatic logic [TOD_W-1:0] time_of_day(logic [4:0] hour, logic [5:0] minute,
                                                   logic [5:0] second);
    return TOD_W'(hour) * 17'd3600 + TOD_W'(minute) * 17'd60 + TOD_W'(second);
  endfunction

endpackage

`default_nettype wire

[rtl/core/dbd_alu.sv]
// Shared adder: one signed add per cycle, operand picked by the sequencer.
`default_nettype none

module dbd_alu
  import dbd_pkg::*;
(
  input  op_t                     op,
  input  logic signed [ACC_W-1:0] acc,
  input  logic [YEAR_W-1:0]       rem,
  input  logic [CNT_W-1:0]        cnt,
  input  logic [8:0]              doy_s,
  input  logic [8:0]              doy_e,
  input  logic                    leap,
  input  logic                    late,
  output logic signed [ACC_W-1:0] sum,
  output logic                    neg
);

  logic signed [ACC_W-1:0] a;
  logic signed [ACC_W-1:0] b;

  always_comb begin
    a = acc;
    b = '0;
    case (op)
      OP_MOD: begin
        // trial subtract of 400 * 2^cnt from the running remainder
        a = $signed(ACC_W'(rem));
        b = -$signed(ACC_W'(CYCLE_LEN) << cnt);
      end
      OP_DOYS: b = -$signed(ACC_W'(doy_s));
      OP_WALK: b = leap ? $signed(DAYS_LEAP) : $signed(DAYS_COMMON);
      OP_DOYE: b = $signed(ACC_W'(doy_e));
      OP_TOD:  b = late ? -24'sd1 : 24'sd0;
      default: b = '0;
    endcase
  end

  assign sum = a + b;
  assign neg = sum[ACC_W-1];

endmodule

`default_nettype wire

[rtl/core/dbd_fsm.sv]
// Sequencer: steps the shared adder through remainder, day-of-year, year walk and time-of-day correction.
`default_nettype none

module dbd_fsm
  import dbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output ctrl_t   ctrl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MOD;
      S_MOD: begin
        if (status.cnt_zero) begin
          state_next = status.year_back ? S_TOD : S_DOYS;
        end
      end
      S_DOYS: state_next = S_WALK;
      S_WALK: if (status.year_done) state_next = S_DOYE;
      S_DOYE: state_next = S_TOD;
      S_TOD:  state_next = S_DONE;
      S_DONE: if (status.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '{in_ready: 1'b0, load: 1'b0, op: OP_NONE, acc_we: 1'b0,
             rem_step: 1'b0, year_step: 1'b0, out_load: 1'b0};
    case (state)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        ctrl.load     = in_valid;
      end
      S_MOD: begin
        ctrl.op       = OP_MOD;
        ctrl.rem_step = 1'b1;
      end
      S_DOYS: begin
        ctrl.op     = OP_DOYS;
        ctrl.acc_we = 1'b1;
      end
      S_WALK: begin
        ctrl.op        = OP_WALK;
        ctrl.acc_we    = !status.year_done;
        ctrl.year_step = !status.year_done;
      end
      S_DOYE: begin
        ctrl.op     = OP_DOYE;
        ctrl.acc_we = 1'b1;
      end
      S_TOD: begin
        ctrl.op     = OP_TOD;
        ctrl.acc_we = 1'b1;
      end
      S_DONE: ctrl.out_load = status.out_free;
      default: ctrl.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/full_days_between_datetimes.sv]
// Top level: whole days between two date-times, iterative year walk.
//
// Usage:
//   Request channel in_valid/in_ready carries both moments (year, month,
//   day, hour, minute, second). Result channel out_valid/out_ready carries
//   whole_days, a 23-bit two's complement count saturated at 4194303.
//   A request is taken only while the sequencer is idle; in_ready is low
//   for the whole computation.
// Sequence per request:
//   take it, reduce the start year modulo 400 on the shared adder, then
//   day-of-year and year walk (one year per cycle through the same adder),
//   time-of-day correction and loading of the output. When the end year is
//   earlier, the day-of-year and walk steps are skipped. The year walk
//   sets the running time.
// Reset: rst (synchronous, active high) returns the sequencer to idle and
//   drops out_valid.
// Stall: a finished result sits in the output register until taken; a new
//   request may be taken meanwhile and holds in its last step until the
//   output register frees up.
`default_nettype none

module full_days_between_datetimes
  import dbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [13:0]       start_year,
  input  logic [3:0]        start_month,
  input  logic [4:0]        start_day,
  input  logic [4:0]        start_hour,
  input  logic [5:0]        start_minute,
  input  logic [5:0]        start_second,
  input  logic [13:0]       end_year,
  input  logic [3:0]        end_month,
  input  logic [4:0]        end_day,
  input  logic [4:0]        end_hour,
  input  logic [5:0]        end_minute,
  input  logic [5:0]        end_second,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [22:0] whole_days
);

  ctrl_t   ctrl;
  status_t status;

  // Request fields held for the whole computation.
  logic [YEAR_W-1:0] start_year_q;
  logic [YEAR_W-1:0] end_year_q;
  logic [3:0]        start_month_q;
  logic [4:0]        start_day_q;
  logic [3:0]        end_month_q;
  logic [4:0]        end_day_q;
  logic              late;

  // Walk state: current year, its remainder modulo 400, running day count.
  logic [YEAR_W-1:0]       year;
  logic [YEAR_W-1:0]       rem;
  logic [CNT_W-1:0]        cnt;
  logic signed [ACC_W-1:0] acc;

  logic signed [ACC_W-1:0] sum;
  logic                    neg;
  logic                    leap;
  logic                    century;
  logic [8:0]              doy_s;
  logic [8:0]              doy_e;
  logic [TOD_W-1:0]        tod_start;
  logic [TOD_W-1:0]        tod_end;
  logic signed [DAYS_W-1:0] result;

  assign tod_start = time_of_day(start_hour, start_minute, start_second);
  assign tod_end   = time_of_day(end_hour, end_minute, end_second);

  // Leap rule from the low year bits and the mod-400 remainder: a century
  // year is leap only when it sits on a 400 boundary.
  assign century = (rem == CENTURY) || (rem == (CENTURY << 1)) ||
                   (rem == (CENTURY + (CENTURY << 1)));
  assign leap    = (year[1:0] == 2'd0) && !century;

  assign doy_s = date_ordinal(start_month_q, start_day_q, leap);
  assign doy_e = date_ordinal(end_month_q, end_day_q, leap);

  assign status.cnt_zero  = (cnt == '0);
  assign status.year_done = (year == end_year_q);
  assign status.year_back = (end_year_q < start_year_q);
  assign status.out_free  = !out_valid || out_ready;

  assign in_ready = ctrl.in_ready;

  dbd_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  dbd_alu u_alu (
    .op    (ctrl.op),
    .acc   (acc),
    .rem   (rem),
    .cnt   (cnt),
    .doy_s (doy_s),
    .doy_e (doy_e),
    .leap  (leap),
    .late  (late),
    .sum   (sum),
    .neg   (neg)
  );

  // Latch the request, then run the remainder and walk steps.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      start_year_q  <= start_year;
      end_year_q    <= end_year;
      start_month_q <= start_month;
      start_day_q   <= start_day;
      end_month_q   <= end_month;
      end_day_q     <= end_day;
      late          <= (tod_end < tod_start);
      year          <= start_year;
      rem           <= start_year;
      cnt           <= MOD_STEPS;
      acc           <= '0;
    end else begin
      if (ctrl.rem_step) begin
        // restoring step: keep the difference when it did not go negative
        if (!neg) begin
          rem <= sum[YEAR_W-1:0];
        end
        cnt <= cnt - 3'd1;
      end
      if (ctrl.year_step) begin
        year <= year + 14'd1;
        rem  <= (rem == CYCLE_LEN - 14'd1) ? '0 : rem + 14'd1;
      end
      if (ctrl.acc_we) begin
        acc <= sum;
      end
    end
  end

  assign result = (acc > RESULT_MAX) ? DAYS_W'(RESULT_MAX) : acc[DAYS_W-1:0];

  // Output register; hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      whole_days <= result;
    end
  end

  // The walk never runs past the end year.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_WALK) |-> (year <= end_year_q))
    else $error("year walk passed the end year");

  // Once reduced, the remainder stays a valid mod-400 value during the walk.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_WALK) |-> (rem < CYCLE_LEN))
    else $error("year remainder out of range during walk");

  // Restoring reduction keeps the remainder below twice the divisor of the current step.
  a_mod_bound: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_MOD) |-> ({2'b00, rem} < ({2'b00, CYCLE_LEN} << (cnt + 3'd1))))
    else $error("remainder reduction lost its bound");

  // A result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
